// File: hw/rtl/vas_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vas_pkg
// Shared types and codes of the variable activity selector.
// ----------------------------------------------------------------------------
package vas_pkg;

    // operation codes carried by the action field
    typedef enum logic [2:0] {
        A_INIT   = 3'd0,
        A_BUMP   = 3'd1,
        A_UNFREE = 3'd2,
        A_FREE   = 3'd3,
        A_DECAY  = 3'd4,
        A_ADJUST = 3'd5,
        A_APPEAR = 3'd6,
        A_PICK   = 3'd7
    } t_action;

    // configuration register indexes
    localparam logic [2:0] CFG_VAR_COUNT  = 3'd0;
    localparam logic [2:0] CFG_DECAY_SLOW = 3'd1;
    localparam logic [2:0] CFG_DECAY_FAST = 3'd2;
    localparam logic [2:0] CFG_RESCALE    = 3'd3;
    localparam logic [2:0] CFG_ACT_LIMIT  = 3'd4;
    localparam logic [2:0] CFG_WIN_LEN    = 3'd5;
    localparam logic [2:0] CFG_AVG_LIMIT  = 3'd6;

    // configuration reset values
    localparam logic [10:0] RST_VAR_COUNT  = 11'd1024;
    localparam logic [15:0] RST_DECAY_SLOW = 16'd31130;
    localparam logic [15:0] RST_DECAY_FAST = 16'd24576;
    localparam logic [15:0] RST_RESCALE    = 16'd32;
    localparam logic [31:0] RST_ACT_LIMIT  = 32'h4000_0000;
    localparam logic [6:0]  RST_WIN_LEN    = 7'd50;
    localparam logic [10:0] RST_AVG_LIMIT  = 11'd3;

    // kinds of sweep over the variable stores
    typedef enum logic [1:0] {
        M_CLEAR = 2'd0,
        M_DEC1  = 2'd1,
        M_DEC2  = 2'd2,
        M_PICK  = 2'd3
    } t_scan;

    // controller to datapath commands
    typedef struct packed {
        logic  load;
        logic  scan_start;
        t_scan scan_mode;
        logic  single_wr;
        logic  adj_sub;
        logic  adj_push;
        logic  adj_mul;
        logic  adj_cmp;
        logic  app_sel_cand;
        logic  phase_cmp;
        logic  out_load;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        t_action action;
        logic    scan_done;
        logic    over;
        logic    cand_valid;
        logic    out_full;
    } t_stat;

endpackage

// File: hw/rtl/vsids_activity_selector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsids_activity_selector
// Variable activity decision heuristic: activity, free marks, appearance
// counts and a decay factor chosen from a moving window of level differences.
// ----------------------------------------------------------------------------
// Bump, free, unfree and appearance make at most one store write; adjust steps
// through subtract, push, multiply and compare. Decay sweeps the N variables in
// use, and again when it rescales; pick sweeps them and reads the phase only
// with a candidate found; one entry per cycle. Init sweeps all MAX_VARS entries.
// One item at a time. After reset a clearing pass over all MAX_VARS entries
// runs before the first item is accepted; configuration writes are taken throughout.
module vsids_activity_selector #(
    parameter int MAX_VARS   = 1024,
    parameter int MAX_WINDOW = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [2:0]        i_cfg_index,
    input  logic [31:0]       i_cfg_data,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [2:0]        i_action,
    input  logic [9:0]        i_var_index,
    input  logic              i_negative,
    input  logic [15:0]       i_bump_amount,
    input  logic signed [8:0] i_appearance_delta,
    input  logic [10:0]       i_level_difference,
    input  logic [15:0]       i_watchers_positive,
    input  logic [15:0]       i_watchers_negative,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [10:0]       o_free_count,
    output logic [9:0]        o_candidate_var,
    output logic              o_candidate_positive,
    output logic              o_candidate_valid,
    output logic              o_rescaled,
    output logic              o_fast_selected
);
    import vas_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    assign o_cfg_ready = 1'b1;

    // sequencer
    vas_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_cmd   (w_cmd),
        .i_stat  (w_stat)
    );

    // stores and arithmetic
    vas_datapath #(.MAX_VARS(MAX_VARS), .MAX_WINDOW(MAX_WINDOW)) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (w_cmd),
        .o_stat               (w_stat),
        .i_cfg_valid          (i_cfg_valid),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .i_action             (i_action),
        .i_var_index          (i_var_index),
        .i_negative           (i_negative),
        .i_bump_amount        (i_bump_amount),
        .i_appearance_delta   (i_appearance_delta),
        .i_level_difference   (i_level_difference),
        .i_watchers_positive  (i_watchers_positive),
        .i_watchers_negative  (i_watchers_negative),
        .o_valid              (o_valid),
        .i_ready              (i_ready),
        .o_free_count         (o_free_count),
        .o_candidate_var      (o_candidate_var),
        .o_candidate_positive (o_candidate_positive),
        .o_candidate_valid    (o_candidate_valid),
        .o_rescaled           (o_rescaled),
        .o_fast_selected      (o_fast_selected)
    );
endmodule

// File: hw/rtl/vas_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vas_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module vas_ram #(
    parameter int W = 32,
    parameter int D = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(D > 1 ? $clog2(D) : 1)-1:0]   i_waddr,
    input  logic [W-1:0]                         i_wdata,
    input  logic [(D > 1 ? $clog2(D) : 1)-1:0]   i_raddr,
    output logic [W-1:0]                         o_rdata
);
    logic [W-1:0] r_mem [D];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: hw/rtl/vas_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vas_ctrl
// Sequencer of the activity selector: steps each operation through the
// datapath and hands the result to the output register.
// ----------------------------------------------------------------------------
module vas_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    output vas_pkg::t_cmd o_cmd,
    input  vas_pkg::t_stat i_stat
);
    import vas_pkg::*;

    typedef enum logic [13:0] {
        S_IDLE    = 14'h0001,
        S_DECODE  = 14'h0002,
        S_CLEAR   = 14'h0004,
        S_SWRITE  = 14'h0008,
        S_DEC1    = 14'h0010,
        S_DEC2    = 14'h0020,
        S_ADJ_SUB = 14'h0040,
        S_ADJ_PSH = 14'h0080,
        S_ADJ_MUL = 14'h0100,
        S_ADJ_CMP = 14'h0200,
        S_PICK    = 14'h0400,
        S_PH_RD   = 14'h0800,
        S_DONE    = 14'h1000,
        S_RCLR    = 14'h2000
    } t_state;

    t_state r_state, n_state;

    // state register; reset starts the clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RCLR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.scan_mode = M_CLEAR;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_stat.action)
                    A_INIT: begin
                        o_cmd.scan_start = 1'b1;
                        o_cmd.scan_mode  = M_CLEAR;
                        n_state = S_CLEAR;
                    end
                    A_BUMP, A_UNFREE, A_FREE, A_APPEAR: n_state = S_SWRITE;
                    A_DECAY: begin
                        o_cmd.scan_start = 1'b1;
                        o_cmd.scan_mode  = M_DEC1;
                        n_state = S_DEC1;
                    end
                    A_ADJUST: n_state = S_ADJ_SUB;
                    A_PICK: begin
                        o_cmd.scan_start = 1'b1;
                        o_cmd.scan_mode  = M_PICK;
                        n_state = S_PICK;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            // clearing sweep after reset, no result
            S_RCLR: begin
                if (i_stat.scan_done) begin
                    n_state = S_IDLE;
                end
            end
            S_CLEAR: begin
                if (i_stat.scan_done) begin
                    n_state = S_DONE;
                end
            end
            S_SWRITE: begin
                o_cmd.single_wr = 1'b1;
                n_state = S_DONE;
            end
            S_DEC1: begin
                if (i_stat.scan_done) begin
                    if (i_stat.over) begin
                        o_cmd.scan_start = 1'b1;
                        o_cmd.scan_mode  = M_DEC2;
                        n_state = S_DEC2;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DEC2: begin
                if (i_stat.scan_done) begin
                    n_state = S_DONE;
                end
            end
            S_ADJ_SUB: begin
                o_cmd.adj_sub = 1'b1;
                n_state = S_ADJ_PSH;
            end
            S_ADJ_PSH: begin
                o_cmd.adj_push = 1'b1;
                n_state = S_ADJ_MUL;
            end
            S_ADJ_MUL: begin
                o_cmd.adj_mul = 1'b1;
                n_state = S_ADJ_CMP;
            end
            S_ADJ_CMP: begin
                o_cmd.adj_cmp = 1'b1;
                n_state = S_DONE;
            end
            S_PICK: begin
                if (i_stat.scan_done) begin
                    o_cmd.app_sel_cand = 1'b1;
                    n_state = i_stat.cand_valid ? S_PH_RD : S_DONE;
                end
            end
            S_PH_RD: begin
                o_cmd.phase_cmp = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!i_stat.out_full) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

// File: hw/rtl/vas_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vas_datapath
// Stores, sweep pipeline, averaging window and result register of the
// activity selector.
// ----------------------------------------------------------------------------
module vas_datapath #(
    parameter int MAX_VARS   = 1024,
    parameter int MAX_WINDOW = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  vas_pkg::t_cmd         i_cmd,
    output vas_pkg::t_stat        o_stat,
    input  logic                  i_cfg_valid,
    input  logic [2:0]            i_cfg_index,
    input  logic [31:0]           i_cfg_data,
    input  logic [2:0]            i_action,
    input  logic [9:0]            i_var_index,
    input  logic                  i_negative,
    input  logic [15:0]           i_bump_amount,
    input  logic signed [8:0]     i_appearance_delta,
    input  logic [10:0]           i_level_difference,
    input  logic [15:0]           i_watchers_positive,
    input  logic [15:0]           i_watchers_negative,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [10:0]           o_free_count,
    output logic [9:0]            o_candidate_var,
    output logic                  o_candidate_positive,
    output logic                  o_candidate_valid,
    output logic                  o_rescaled,
    output logic                  o_fast_selected
);
    import vas_pkg::*;

    localparam int VW = $clog2(MAX_VARS);
    localparam int CW = VW + 1;
    localparam int WA = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int FW = $clog2(MAX_WINDOW + 1);
    localparam int SW = 11 + FW;

    // configuration registers
    logic [10:0] r_cfg_count, r_cfg_alim;
    logic [15:0] r_cfg_slow, r_cfg_fast, r_cfg_resc;
    logic [31:0] r_cfg_limit;
    logic [6:0]  r_cfg_wlen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_count <= RST_VAR_COUNT;
            r_cfg_slow  <= RST_DECAY_SLOW;
            r_cfg_fast  <= RST_DECAY_FAST;
            r_cfg_resc  <= RST_RESCALE;
            r_cfg_limit <= RST_ACT_LIMIT;
            r_cfg_wlen  <= RST_WIN_LEN;
            r_cfg_alim  <= RST_AVG_LIMIT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_VAR_COUNT:  r_cfg_count <= i_cfg_data[10:0];
                CFG_DECAY_SLOW: r_cfg_slow  <= i_cfg_data[15:0];
                CFG_DECAY_FAST: r_cfg_fast  <= i_cfg_data[15:0];
                CFG_RESCALE:    r_cfg_resc  <= i_cfg_data[15:0];
                CFG_ACT_LIMIT:  r_cfg_limit <= i_cfg_data;
                CFG_WIN_LEN:    r_cfg_wlen  <= i_cfg_data[6:0];
                CFG_AVG_LIMIT:  r_cfg_alim  <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // latched input item
    t_action     r_action;
    logic [9:0]  r_var;
    logic        r_neg;
    logic [15:0] r_bump, r_wpos, r_wneg;
    logic signed [8:0] r_delta;
    logic [10:0] r_diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_action <= A_INIT;
        end else if (i_cmd.load) begin
            r_action <= t_action'(i_action);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_var   <= i_var_index;
            r_neg   <= i_negative;
            r_bump  <= i_bump_amount;
            r_delta <= i_appearance_delta;
            r_diff  <= i_level_difference;
            r_wpos  <= i_watchers_positive;
            r_wneg  <= i_watchers_negative;
        end
    end

    logic [16:0]   w_var_ext;
    logic [VW-1:0] w_var_addr;
    logic          w_in_use;
    assign w_var_ext  = 17'(r_var);
    assign w_var_addr = w_var_ext[VW-1:0];

    // variable bookkeeping
    logic [CW-1:0] r_in_use_cnt, r_free_total, r_n;
    assign w_in_use = w_var_ext < 17'(r_in_use_cnt);

    logic [CW-1:0] w_init_n;
    assign w_init_n = (17'(r_cfg_count) > 17'(MAX_VARS)) ? CW'(MAX_VARS) : CW'(r_cfg_count);

    // sweep control
    t_scan         r_mode;
    t_scan         w_lim_mode;
    logic          r_busy;
    logic [VW-1:0] r_idx;
    logic          r_s1_vld, r_s2_vld;
    logic [VW-1:0] r_s1_addr, r_s2_addr;
    logic [47:0]   r_s2_prod;
    logic          r_over;
    logic [CW-1:0] w_lim;
    logic          w_clr_wr;
    logic [15:0]   r_decay_q;

    // sweep length follows the starting mode, then the running one
    assign w_lim_mode = i_cmd.scan_start ? i_cmd.scan_mode : r_mode;
    assign w_lim    = (w_lim_mode == M_CLEAR) ? CW'(MAX_VARS) : r_in_use_cnt;
    assign w_clr_wr = r_busy && (r_mode == M_CLEAR);

    // store read data
    logic [31:0] w_act_rd, w_app_rd;
    logic        w_free_rd;
    logic [10:0] w_win_rd;

    // best candidate of a pick sweep
    logic [VW-1:0] r_cand;
    logic [31:0]   r_best;
    logic          r_cvalid, r_pos;

    // decay product after the shift, saturated
    logic [32:0] w_shifted;
    logic [31:0] w_sat;
    assign w_shifted = r_s2_prod[47:15];
    assign w_sat     = w_shifted[32] ? 32'hFFFF_FFFF : w_shifted[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b1;
            r_idx    <= '0;
            r_mode   <= M_CLEAR;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_over   <= 1'b0;
            r_cvalid <= 1'b0;
            r_n      <= CW'(MAX_VARS);
        end else begin
            if (i_cmd.scan_start) begin
                r_mode <= i_cmd.scan_mode;
                r_busy <= (w_lim != '0);
                r_idx  <= '0;
                if (i_cmd.scan_mode == M_CLEAR) begin
                    r_n <= w_init_n;
                end
                if (i_cmd.scan_mode == M_DEC1) begin
                    r_over <= 1'b0;
                end
                if (i_cmd.scan_mode == M_PICK) begin
                    r_cvalid <= 1'b0;
                end
            end else if (r_busy) begin
                if ({1'b0, r_idx} == w_lim - CW'(1)) begin
                    r_busy <= 1'b0;
                end else begin
                    r_idx <= r_idx + VW'(1);
                end
            end
            // stage one: read issued for a decay or pick sweep
            r_s1_vld  <= r_busy && (r_mode != M_CLEAR);
            r_s1_addr <= r_idx;
            // stage two: decay product registered
            r_s2_vld  <= r_s1_vld && (r_mode != M_PICK);
            r_s2_addr <= r_s1_addr;
            if (r_s2_vld && (r_mode == M_DEC1) && (w_sat > r_cfg_limit)) begin
                r_over <= 1'b1;
            end
            if (r_s1_vld && (r_mode == M_PICK) && w_free_rd
                    && (!r_cvalid || w_act_rd >= r_best)) begin
                r_cvalid <= 1'b1;
            end
        end
    end

    // pick comparison and product register
    always_ff @(posedge i_clk) begin
        r_s2_prod <= w_act_rd * ((r_mode == M_DEC2) ? r_cfg_resc : r_decay_q);
        if (r_s1_vld && (r_mode == M_PICK) && w_free_rd
                && (!r_cvalid || w_act_rd >= r_best)) begin
            r_cand <= r_s1_addr;
            r_best <= w_act_rd;
        end
    end

    // single variable updates
    logic [32:0]        w_bump_sum;
    logic [31:0]        w_bump_sat;
    logic signed [15:0] w_half, w_half_new;
    logic signed [16:0] w_half_sum;
    logic [31:0]        w_app_new;
    logic               w_bump_wr, w_unf_wr, w_free_wr, w_app_wr;

    assign w_bump_sum = {1'b0, w_act_rd} + {1'b0, r_bump, 16'h0000};
    assign w_bump_sat = w_bump_sum[32] ? 32'hFFFF_FFFF : w_bump_sum[31:0];
    assign w_half     = r_neg ? $signed(w_app_rd[31:16]) : $signed(w_app_rd[15:0]);
    assign w_half_sum = 17'(w_half) + 17'(r_delta);
    always_comb begin
        if (w_half_sum > 17'sd32767) begin
            w_half_new = 16'sh7FFF;
        end else if (w_half_sum < -17'sd32768) begin
            w_half_new = 16'sh8000;
        end else begin
            w_half_new = w_half_sum[15:0];
        end
    end
    assign w_app_new = r_neg ? {w_half_new, w_app_rd[15:0]} : {w_app_rd[31:16], w_half_new};

    assign w_bump_wr = i_cmd.single_wr && w_in_use && (r_action == A_BUMP);
    assign w_unf_wr  = i_cmd.single_wr && w_in_use && (r_action == A_UNFREE) && w_free_rd;
    assign w_free_wr = i_cmd.single_wr && w_in_use && (r_action == A_FREE) && !w_free_rd;
    assign w_app_wr  = i_cmd.single_wr && w_in_use && (r_action == A_APPEAR);

    // in-use and free counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use_cnt <= CW'(MAX_VARS);
            r_free_total <= CW'(MAX_VARS);
        end else if (i_cmd.scan_start && (i_cmd.scan_mode == M_CLEAR)) begin
            r_in_use_cnt <= w_init_n;
            r_free_total <= w_init_n;
        end else if (w_unf_wr) begin
            r_free_total <= r_free_total - CW'(1);
        end else if (w_free_wr) begin
            r_free_total <= r_free_total + CW'(1);
        end
    end

    // activity store
    logic          w_act_we;
    logic [VW-1:0] w_act_wa, w_rd_addr;
    logic [31:0]   w_act_wd;
    always_comb begin
        w_act_we = 1'b0;
        w_act_wa = w_var_addr;
        w_act_wd = w_bump_sat;
        if (w_clr_wr) begin
            w_act_we = 1'b1;
            w_act_wa = r_idx;
            w_act_wd = '0;
        end else if (r_s2_vld) begin
            w_act_we = 1'b1;
            w_act_wa = r_s2_addr;
            w_act_wd = w_sat;
        end else if (w_bump_wr) begin
            w_act_we = 1'b1;
        end
    end
    assign w_rd_addr = r_busy ? r_idx : w_var_addr;

    vas_ram #(.W(32), .D(MAX_VARS)) u_act_ram (
        .i_clk   (i_clk),
        .i_we    (w_act_we),
        .i_waddr (w_act_wa),
        .i_wdata (w_act_wd),
        .i_raddr (w_rd_addr),
        .o_rdata (w_act_rd)
    );

    // free marks
    logic w_fm_we, w_fm_wd;
    assign w_fm_we = w_clr_wr || w_unf_wr || w_free_wr;
    assign w_fm_wd = w_clr_wr ? ({1'b0, r_idx} < r_n) : w_free_wr;

    vas_ram #(.W(1), .D(MAX_VARS)) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (w_fm_we),
        .i_waddr (w_clr_wr ? r_idx : w_var_addr),
        .i_wdata (w_fm_wd),
        .i_raddr (w_rd_addr),
        .o_rdata (w_free_rd)
    );

    // appearance counts, negative polarity in the upper half
    vas_ram #(.W(32), .D(MAX_VARS)) u_app_ram (
        .i_clk   (i_clk),
        .i_we    (w_clr_wr || w_app_wr),
        .i_waddr (w_clr_wr ? r_idx : w_var_addr),
        .i_wdata (w_clr_wr ? 32'h0 : w_app_new),
        .i_raddr (i_cmd.app_sel_cand ? r_cand : w_var_addr),
        .o_rdata (w_app_rd)
    );

    // phase choice for the picked variable
    logic signed [17:0] w_ph_p, w_ph_n;
    assign w_ph_p = 18'($signed(w_app_rd[15:0])) - $signed({2'b00, r_wneg});
    assign w_ph_n = 18'($signed(w_app_rd[31:16])) - $signed({2'b00, r_wpos});

    always_ff @(posedge i_clk) begin
        if (i_cmd.phase_cmp) begin
            r_pos <= (w_ph_p > w_ph_n);
        end
    end

    // averaging window
    logic [WA-1:0]   r_head;
    logic [FW-1:0]   r_fill;
    logic [SW-1:0]   r_sum;
    logic [12+FW-1:0] r_thresh;
    logic            r_fast;
    logic [10:0]     w_len;
    logic [11:0]     w_old;
    logic            w_drop;

    always_comb begin
        if (r_cfg_wlen == 7'd0) begin
            w_len = 11'd1;
        end else if (11'(r_cfg_wlen) > 11'(MAX_WINDOW)) begin
            w_len = 11'(MAX_WINDOW);
        end else begin
            w_len = 11'(r_cfg_wlen);
        end
        if (12'(r_head) >= 12'(r_fill)) begin
            w_old = 12'(r_head) - 12'(r_fill);
        end else begin
            w_old = 12'(r_head) + 12'(MAX_WINDOW) - 12'(r_fill);
        end
    end
    assign w_drop = 11'(r_fill) >= w_len;

    vas_ram #(.W(11), .D(MAX_WINDOW)) u_win_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.adj_push),
        .i_waddr (r_head),
        .i_wdata (r_diff),
        .i_raddr (w_old[WA-1:0]),
        .o_rdata (w_win_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_fill    <= '0;
            r_sum     <= '0;
            r_decay_q <= RST_DECAY_SLOW;
            r_fast    <= 1'b0;
        end else begin
            if (i_cmd.adj_sub && w_drop) begin
                r_sum  <= r_sum - SW'(w_win_rd);
                r_fill <= r_fill - FW'(1);
            end
            if (i_cmd.adj_push) begin
                r_head <= (r_head == WA'(MAX_WINDOW - 1)) ? '0 : r_head + WA'(1);
                r_fill <= r_fill + FW'(1);
                r_sum  <= r_sum + SW'(r_diff);
            end
            // average below the limit plus one: sum below (limit + 1) * fill
            if (i_cmd.adj_cmp) begin
                r_fast    <= !((12+FW)'(r_sum) < r_thresh);
                r_decay_q <= ((12+FW)'(r_sum) < r_thresh) ? r_cfg_slow : r_cfg_fast;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.adj_mul) begin
            r_thresh <= ({1'b0, r_cfg_alim} + 12'd1) * r_fill;
        end
    end

    // result register
    logic w_is_pick;
    assign w_is_pick = (r_action == A_PICK) && r_cvalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            o_valid <= 1'b1;
        end else if (i_ready) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_free_count         <= 11'(r_free_total);
            o_candidate_var      <= w_is_pick ? 10'(r_cand) : 10'd0;
            o_candidate_positive <= w_is_pick && r_pos;
            o_candidate_valid    <= w_is_pick;
            o_rescaled           <= (r_action == A_DECAY) && r_over;
            o_fast_selected      <= r_fast;
        end
    end

    // status to the controller
    assign o_stat.action     = r_action;
    assign o_stat.scan_done  = !r_busy && !r_s1_vld && !r_s2_vld;
    assign o_stat.over       = r_over;
    assign o_stat.cand_valid = r_cvalid;
    assign o_stat.out_full   = o_valid && !i_ready;
endmodule
